### sv/b13ds_pkg.sv
// Shared types, constants and helpers of the 13-tap bloom downsample unit.
package b13ds_pkg;

   localparam int CHANNEL_BITS      = 16;
   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int HEIGHT_LIMIT      = 4096;
   localparam int WIDTH_REG_W       = 12;
   localparam int HEIGHT_W          = 13;
   localparam int ROW_W             = 12;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 13;
   localparam int PIXEL_W           = 3 * CHANNEL_BITS;
   localparam int GV_W              = CHANNEL_BITS + 2;
   localparam int RECIP_W           = 25;
   localparam int ACC_W             = CHANNEL_BITS + RECIP_W + 1;
   localparam int TOT_W             = RECIP_W + 2;
   localparam int LANES             = 5;
   localparam int TAPS              = 13;

   localparam logic [31:0] LUMA_R = 32'd13933;
   localparam logic [31:0] LUMA_G = 32'd46871;
   localparam logic [31:0] LUMA_B = 32'd4732;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KARIS_MODE   = 2'd2;

   // channel 0 red, 1 green, 2 blue
   typedef logic [2:0][CHANNEL_BITS-1:0] pixel_type;

   typedef struct packed {
      logic [4:0][2:0] col_back;
      logic [4:0][2:0] row_back;
   } window_sel_type;

   typedef struct packed {
      logic                done;
      logic [2:0][GV_W-1:0] value;
   } lane_result_type;

   localparam logic [2:0] TAP_COL [TAPS] = '{3'd0, 3'd2, 3'd4, 3'd0, 3'd2, 3'd4, 3'd0,
                                             3'd2, 3'd4, 3'd1, 3'd3, 3'd1, 3'd3};
   localparam logic [2:0] TAP_ROW [TAPS] = '{3'd0, 3'd0, 3'd0, 3'd2, 3'd2, 3'd2, 3'd4,
                                             3'd4, 3'd4, 3'd1, 3'd1, 3'd3, 3'd3};
   localparam logic [3:0] GROUP_TAP [LANES][4] = '{
      '{4'd9, 4'd10, 4'd11, 4'd12},
      '{4'd0, 4'd1,  4'd3,  4'd4},
      '{4'd1, 4'd2,  4'd4,  4'd5},
      '{4'd3, 4'd4,  4'd6,  4'd7},
      '{4'd4, 4'd5,  4'd7,  4'd8}
   };

   // distance back from pos to clamp(2*oidx + j - 2, 0, size - 1)
   function automatic logic [2:0] back_off(input logic [15:0] pos, input logic [15:0] oidx,
                                           input logic [15:0] size, input logic [2:0] j);
      logic signed [18:0] t;
      logic signed [18:0] lim;
      logic signed [18:0] d;
      t   = $signed({2'b00, oidx, 1'b0}) + $signed({16'd0, j}) - 19'sd2;
      lim = $signed({3'b000, size}) - 19'sd1;
      if (t < 19'sd0) begin
         t = 19'sd0;
      end else if (t > lim) begin
         t = lim;
      end
      d = $signed({3'b000, pos}) - t;
      return d[2:0];
   endfunction

endpackage

### sv/b13ds_window.sv
// Row buffer banks and 5x5 tap window with clamped tap selection.
module b13ds_window #(
   parameter int MAX_WIDTH = b13ds_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]           col,
   input  logic [1:0]                             slot,
   input  b13ds_pkg::pixel_type                   pix,
   input  b13ds_pkg::window_sel_type              sel,
   input  logic                                   emit,
   output logic                                   tap_valid,
   output b13ds_pkg::pixel_type [b13ds_pkg::TAPS-1:0] taps
);
   import b13ds_pkg::*;

   pixel_type [3:0]     rd_ff;
   pixel_type           pix_b_ff;
   logic [1:0]          slot_b_ff;
   window_sel_type      sel_b_ff;
   logic                vb_ff;
   logic                emit_b_ff;
   logic                vc_ff;
   logic [4:0][2:0]     colb_c_ff;
   pixel_type [4:0][4:0] win_ff;
   pixel_type [4:0]     raw;
   pixel_type [4:0]     colv;

   for (genvar s = 0; s < 4; s++) begin : g_bank
      pixel_type mem_ff [MAX_WIDTH];
      always_ff @(posedge clock) begin
         if (wr_en) begin
            if (slot == 2'(s)) begin
               mem_ff[col] <= pix;
            end
            rd_ff[s] <= mem_ff[col];
         end
      end
   end

   always_comb begin
      raw[0] = pix_b_ff;
      for (int e = 1; e < 5; e++) begin
         raw[e] = rd_ff[2'(slot_b_ff - 2'(e))];
      end
      for (int j = 0; j < 5; j++) begin
         case (sel_b_ff.row_back[j])
            3'd0:    colv[j] = raw[0];
            3'd1:    colv[j] = raw[1];
            3'd2:    colv[j] = raw[2];
            3'd3:    colv[j] = raw[3];
            default: colv[j] = raw[4];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         vb_ff <= wr_en;
         vc_ff <= vb_ff && emit_b_ff;
      end
      if (wr_en) begin
         pix_b_ff  <= pix;
         slot_b_ff <= slot;
         sel_b_ff  <= sel;
         emit_b_ff <= emit;
      end
      if (vb_ff) begin
         win_ff[0] <= colv;
         for (int d = 1; d < 5; d++) begin
            win_ff[d] <= win_ff[d-1];
         end
         colb_c_ff <= sel_b_ff.col_back;
      end
   end

   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         case (colb_c_ff[TAP_COL[k]])
            3'd0:    taps[k] = win_ff[0][TAP_ROW[k]];
            3'd1:    taps[k] = win_ff[1][TAP_ROW[k]];
            3'd2:    taps[k] = win_ff[2][TAP_ROW[k]];
            3'd3:    taps[k] = win_ff[3][TAP_ROW[k]];
            default: taps[k] = win_ff[4][TAP_ROW[k]];
         endcase
      end
   end

   assign tap_valid = vc_ff;

endmodule

### sv/b13ds_lane.sv
// One group lane: plain four-tap sum or luma-weighted average of four samples.
module b13ds_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          karis,
   input  b13ds_pkg::pixel_type [3:0]    samples,
   input  logic                          ack,
   output b13ds_pkg::lane_result_type    result
);
   import b13ds_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_LUMA, S_RECIP, S_MUL, S_DIVI, S_DIV, S_DONE
   } state_type;

   state_type                   state_ff;
   pixel_type [3:0]             smp_ff;
   logic [1:0]                  idx_ff;
   logic [16:0]                 den_ff;
   logic [16:0]                 rem_ff;
   logic [RECIP_W-1:0]          q_ff;
   logic [4:0]                  cnt_ff;
   logic [2:0][ACC_W-1:0]       acc_ff;
   logic [TOT_W-1:0]            tot_ff;
   logic [2:0][TOT_W-1:0]       drem_ff;
   logic [2:0][CHANNEL_BITS-1:0] dlo_ff;
   logic [2:0][CHANNEL_BITS-1:0] dq_ff;
   logic [2:0][GV_W-1:0]        val_ff;

   pixel_type                   cur;
   logic [31:0]                 lsum;
   logic [17:0]                 rsh;
   logic                        rge;
   logic [2:0][TOT_W:0]         dsh;
   logic [2:0]                  dge;

   always_comb begin
      cur  = smp_ff[idx_ff];
      lsum = 32'(cur[0]) * LUMA_R + 32'(cur[1]) * LUMA_G + 32'(cur[2]) * LUMA_B;
      rsh  = {rem_ff, 1'b0};
      rge  = rsh >= {1'b0, den_ff};
      for (int ch = 0; ch < 3; ch++) begin
         dsh[ch] = {drem_ff[ch], dlo_ff[ch][CHANNEL_BITS-1]};
         dge[ch] = dsh[ch] >= {1'b0, tot_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  smp_ff <= samples;
                  idx_ff <= 2'd0;
                  acc_ff <= '0;
                  tot_ff <= '0;
                  if (karis) begin
                     state_ff <= S_LUMA;
                  end else begin
                     for (int ch = 0; ch < 3; ch++) begin
                        val_ff[ch] <= GV_W'(samples[0][ch]) + GV_W'(samples[1][ch]) +
                                      GV_W'(samples[2][ch]) + GV_W'(samples[3][ch]);
                     end
                     state_ff <= S_DONE;
                  end
               end
            end
            S_LUMA: begin
               den_ff   <= 17'(lsum[31:16]) + 17'd256;
               rem_ff   <= 17'd128;
               q_ff     <= '0;
               cnt_ff   <= 5'(RECIP_W - 1);
               state_ff <= S_RECIP;
            end
            S_RECIP: begin
               rem_ff <= rge ? 17'(rsh - {1'b0, den_ff}) : rsh[16:0];
               q_ff   <= {q_ff[RECIP_W-2:0], rge};
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               for (int ch = 0; ch < 3; ch++) begin
                  acc_ff[ch] <= acc_ff[ch] + ACC_W'(cur[ch]) * ACC_W'(q_ff);
               end
               tot_ff <= tot_ff + TOT_W'(q_ff);
               idx_ff <= idx_ff + 2'd1;
               state_ff <= (idx_ff == 2'd3) ? S_DIVI : S_LUMA;
            end
            S_DIVI: begin
               for (int ch = 0; ch < 3; ch++) begin
                  drem_ff[ch] <= TOT_W'(acc_ff[ch][ACC_W-1:CHANNEL_BITS]);
                  dlo_ff[ch]  <= acc_ff[ch][CHANNEL_BITS-1:0];
               end
               dq_ff  <= '0;
               cnt_ff <= 5'(CHANNEL_BITS - 1);
               if (tot_ff == '0) begin
                  val_ff   <= '0;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               for (int ch = 0; ch < 3; ch++) begin
                  drem_ff[ch] <= dge[ch] ? TOT_W'(dsh[ch] - {1'b0, tot_ff}) : dsh[ch][TOT_W-1:0];
                  dlo_ff[ch]  <= {dlo_ff[ch][CHANNEL_BITS-2:0], 1'b0};
                  dq_ff[ch]   <= {dq_ff[ch][CHANNEL_BITS-2:0], dge[ch]};
                  if (cnt_ff == 5'd0) begin
                     val_ff[ch] <= GV_W'({dq_ff[ch][CHANNEL_BITS-2:0], dge[ch]});
                  end
               end
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == 5'd0) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (ack) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign result.done  = (state_ff == S_DONE);
   assign result.value = val_ff;

endmodule

### sv/b13ds_merge.sv
// Weighted merge of the five group lanes into the output register.
module b13ds_merge (
   input  logic                                            clock,
   input  logic                                            reset,
   input  b13ds_pkg::lane_result_type [b13ds_pkg::LANES-1:0] lanes,
   input  logic                                            karis,
   input  logic                                            frame_last,
   output logic                                            ack,
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   output logic [b13ds_pkg::PIXEL_W-1:0]                   rsp_tdata,
   output logic                                            rsp_tlast
);
   import b13ds_pkg::*;

   localparam int SUM_W = GV_W + 3;

   logic                 vld_ff;
   pixel_type            data_ff;
   logic                 last_ff;
   logic                 all_done;
   logic [2:0][SUM_W-1:0] s;
   pixel_type            merged;

   always_comb begin
      all_done = 1'b1;
      for (int g = 0; g < LANES; g++) begin
         all_done = all_done & lanes[g].done;
      end
      for (int ch = 0; ch < 3; ch++) begin
         s[ch] = (SUM_W'(lanes[0].value[ch]) << 2) + SUM_W'(lanes[1].value[ch]) +
                 SUM_W'(lanes[2].value[ch]) + SUM_W'(lanes[3].value[ch]) +
                 SUM_W'(lanes[4].value[ch]);
         merged[ch] = karis ? s[ch][CHANNEL_BITS+2:3] : s[ch][CHANNEL_BITS+4:5];
      end
   end

   assign ack = all_done && (!vld_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (ack) begin
         vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         vld_ff <= 1'b0;
      end
      if (ack) begin
         data_ff <= merged;
         last_ff <= frame_last;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

### sv/bloom_13tap_downsample_unit.sv
// Top level of the 13-tap bloom downsample unit: counters, emit decode, lanes, merge.
//
// req_*: source RGB pixels in raster order, one beat per pixel (Q8.8 channels).
// rsp_*: half-size image pixels, rsp_tlast on the final pixel of the frame.
// csr_*: register writes (width, height, Karis mode); a size write restarts
//        the frame. Write only while idle.
// Non-emitting pixels are taken one per cycle while req_tready is open. A
// pixel that completes an output window closes req_tready until the five
// group lanes finish: a plain-mode lane sums its four samples directly, a
// Karis-mode lane runs the luma, 25-step reciprocal and multiply of each of
// its four samples in turn and then the group divide.
// The result sits in an output register; a stalled receiver holds it and,
// once the next result is ready, holds the lanes and req_tready.
// Reset clears counters and registers (width 1, height 1, plain mode); the
// row buffer holds no reset value and needs none.
module bloom_13tap_downsample_unit #(
   parameter int MAX_WIDTH = b13ds_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [b13ds_pkg::PIXEL_W-1:0]       req_tdata,   // red_in, green_in, blue_in
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [b13ds_pkg::PIXEL_W-1:0]       rsp_tdata,   // red_out, green_out, blue_out
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [b13ds_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [b13ds_pkg::CSR_DATA_W-1:0]    csr_data
);
   import b13ds_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WEFF_W = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;

   logic [WIDTH_REG_W-1:0] width_ff;
   logic [HEIGHT_W-1:0]    height_ff;
   logic                   karis_ff;
   logic [COL_W-1:0]       col_ff;
   logic [ROW_W-1:0]       row_ff;
   logic                   hold_ff;
   logic                   last_ff;

   logic                   accept;
   logic                   csr_fire;
   logic [WEFF_W-1:0]      w_eff, nx, c_ext, ox;
   logic [HEIGHT_W-1:0]    h_eff, ny, r_ext, oy;
   logic                   last_col, last_row, x_emit, y_emit, emit, frame_end;
   window_sel_type         sel;
   logic                   tap_valid;
   pixel_type [TAPS-1:0]   taps;
   pixel_type [LANES-1:0][3:0] lane_samples;
   lane_result_type [LANES-1:0] lane_res;
   logic                   ack;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !hold_ff;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WEFF_W'(1);
      end else if (WEFF_W'(width_ff) > WEFF_W'(MAX_WIDTH)) begin
         w_eff = WEFF_W'(MAX_WIDTH);
      end else begin
         w_eff = WEFF_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HEIGHT_W'(1);
      end else if (height_ff > HEIGHT_W'(HEIGHT_LIMIT)) begin
         h_eff = HEIGHT_W'(HEIGHT_LIMIT);
      end else begin
         h_eff = height_ff;
      end
      nx = ((w_eff >> 1) == '0) ? WEFF_W'(1) : (w_eff >> 1);
      ny = ((h_eff >> 1) == '0) ? HEIGHT_W'(1) : (h_eff >> 1);
      c_ext    = WEFF_W'(col_ff);
      r_ext    = HEIGHT_W'(row_ff);
      last_col = (c_ext + WEFF_W'(1)) == w_eff;
      last_row = (r_ext + HEIGHT_W'(1)) == h_eff;
      x_emit   = last_col || (c_ext >= WEFF_W'(2) && !col_ff[0]);
      y_emit   = last_row || (r_ext >= HEIGHT_W'(2) && !row_ff[0]);
      ox       = last_col ? nx - WEFF_W'(1) : (c_ext - WEFF_W'(2)) >> 1;
      oy       = last_row ? ny - HEIGHT_W'(1) : (r_ext - HEIGHT_W'(2)) >> 1;
      emit     = x_emit && y_emit;
      frame_end = (ox == nx - WEFF_W'(1)) && (oy == ny - HEIGHT_W'(1));
      for (int j = 0; j < 5; j++) begin
         sel.col_back[j] = back_off(16'(c_ext), 16'(ox), 16'(w_eff), 3'(j));
         sel.row_back[j] = back_off(16'(r_ext), 16'(oy), 16'(h_eff), 3'(j));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_W'(1);
         height_ff <= HEIGHT_W'(1);
         karis_ff  <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         hold_ff   <= 1'b0;
      end else begin
         if (csr_fire) begin
            unique case (csr_index)
               CSR_IMAGE_WIDTH: begin
                  width_ff <= csr_data[WIDTH_REG_W-1:0];
                  col_ff   <= '0;
                  row_ff   <= '0;
               end
               CSR_IMAGE_HEIGHT: begin
                  height_ff <= csr_data;
                  col_ff    <= '0;
                  row_ff    <= '0;
               end
               CSR_KARIS_MODE: karis_ff <= csr_data[0];
               default: ;
            endcase
         end else if (accept) begin
            if (last_col) begin
               col_ff <= '0;
               row_ff <= last_row ? '0 : row_ff + ROW_W'(1);
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end
         if (accept && emit) begin
            hold_ff <= 1'b1;
         end else if (ack) begin
            hold_ff <= 1'b0;
         end
      end
      if (accept && emit) begin
         last_ff <= frame_end;
      end
   end

   b13ds_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept),
      .col       (col_ff),
      .slot      (row_ff[1:0]),
      .pix       (pixel_type'(req_tdata)),
      .sel       (sel),
      .emit      (emit),
      .tap_valid (tap_valid),
      .taps      (taps)
   );

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      for (genvar i = 0; i < 4; i++) begin : g_smp
         assign lane_samples[g][i] = taps[GROUP_TAP[g][i]];
      end
      b13ds_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (tap_valid),
         .karis   (karis_ff),
         .samples (lane_samples[g]),
         .ack     (ack),
         .result  (lane_res[g])
      );
   end

   b13ds_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .lanes      (lane_res),
      .karis      (karis_ff),
      .frame_last (last_ff),
      .ack        (ack),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### bench/tb.sv
// Testbench for the 13-tap bloom downsample unit: streams frames, predicts output pixels.
`timescale 1ns / 100ps

module tb;
   import b13ds_pkg::*;

   localparam int ROW_SPAN = 2048;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        last;
   } out_pixel_type;

   logic                   clock = 0;
   logic                   reset = 1;
   logic                   req_tvalid = 0;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 0;
   logic [PIXEL_W-1:0]     rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   bloom_13tap_downsample_unit uut (.*);

   // downsample predictor state
   logic [PIXEL_W-1:0] line_mem [4*ROW_SPAN];
   logic [PIXEL_W-1:0] evicted [5];
   int unsigned        col_pos, row_pos, width_reg, height_reg, karis_on;

   out_pixel_type pending_pixels [$];
   int         err_count, pixels_sent, pixels_seen, frame_count, karis_pixels;
   bit         steady;

   initial forever #5 clock = ~clock;

   initial begin
      #20ms;
      $display("tb: errors");
      $finish;
   end

   always @(posedge clock) rsp_tready <= steady || ($urandom_range(99) >= 26);

   function automatic int unsigned eff_width();
      if (width_reg < 1) return 1;
      return width_reg > ROW_SPAN ? ROW_SPAN : width_reg;
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg < 1) return 1;
      return height_reg > HEIGHT_LIMIT ? HEIGHT_LIMIT : height_reg;
   endfunction

   function automatic int out_index(int unsigned pos, int unsigned n);
      int unsigned nout;
      nout = n / 2;
      if (nout < 1) nout = 1;
      if (pos + 1 == n) return nout - 1;
      if (pos >= 2 && pos % 2 == 0) return (pos - 2) / 2;
      return -1;
   endfunction

   function automatic logic [PIXEL_W-1:0] read_tap(int unsigned tr, int unsigned tc,
                                                  int unsigned cr, int unsigned cc);
      if (tr != cr && cr >= tr && cr - tr == 4) begin
         if (tc <= cc && cc - tc < 5) return evicted[cc - tc];
         return '0;
      end
      return line_mem[(tr % 4) * ROW_SPAN + tc];
   endfunction

   function automatic longint unsigned sample_weight(logic [PIXEL_W-1:0] p);
      longint unsigned luma;
      luma = (64'd13933 * p[15:0] + 64'd46871 * p[31:16] + 64'd4732 * p[47:32]) >> 16;
      return (64'd1 << 32) / (64'd256 + luma);
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_IMAGE_WIDTH: begin
            width_reg = val[11:0];
            col_pos = 0;
            row_pos = 0;
         end
         CSR_IMAGE_HEIGHT: begin
            height_reg = val;
            col_pos = 0;
            row_pos = 0;
         end
         CSR_KARIS_MODE: karis_on = val[0];
         default: ;
      endcase
   endfunction

   function automatic bit downsample_pixel(logic [PIXEL_W-1:0] px, output out_pixel_type res);
      int                dx [13] = '{-2, 0, 2, -2, 0, 2, -2, 0, 2, -1, 1, -1, 1};
      int                dy [13] = '{-2, -2, -2, 0, 0, 0, 2, 2, 2, -1, -1, 1, 1};
      int                grp [5][4] = '{'{9, 10, 11, 12}, '{0, 1, 3, 4}, '{1, 2, 4, 5},
                                        '{3, 4, 6, 7}, '{4, 5, 7, 8}};
      logic [PIXEL_W-1:0] tap [13];
      longint unsigned    acc [3], sum [3], wt, total, gv;
      int unsigned        w, h, r, c, slot, tc, tr;
      int                 ox, oy, t;
      bit                 hit;
      w = eff_width();
      h = eff_height();
      r = row_pos;
      c = col_pos;
      hit = 0;
      if (c >= w) c = w - 1;
      slot = (r % 4) * ROW_SPAN + c;
      for (int k = 4; k > 0; k--) evicted[k] = evicted[k-1];
      evicted[0] = line_mem[slot];
      line_mem[slot] = px;
      ox = out_index(c, w);
      oy = out_index(r, h);
      if (ox >= 0 && oy >= 0) begin
         for (int k = 0; k < 13; k++) begin
            t = 2 * ox + dx[k];
            tc = t < 0 ? 0 : (t > int'(w) - 1 ? w - 1 : t);
            t = 2 * oy + dy[k];
            tr = t < 0 ? 0 : (t > int'(h) - 1 ? h - 1 : t);
            tap[k] = read_tap(tr, tc, r, c);
         end
         sum = '{0, 0, 0};
         for (int g = 0; g < 5; g++) begin
            acc = '{0, 0, 0};
            total = 0;
            for (int j = 0; j < 4; j++) begin
               wt = karis_on ? sample_weight(tap[grp[g][j]]) : 1;
               for (int ch = 0; ch < 3; ch++) acc[ch] += tap[grp[g][j]][ch*16 +: 16] * wt;
               total += wt;
            end
            for (int ch = 0; ch < 3; ch++) begin
               if (!karis_on) gv = acc[ch];
               else gv = total > 0 ? acc[ch] / total : 0;
               sum[ch] += (g == 0) ? 4 * gv : gv;
            end
         end
         for (int ch = 0; ch < 3; ch++) sum[ch] = karis_on ? sum[ch] >> 3 : sum[ch] >> 5;
         res.red = sum[0][15:0];
         res.green = sum[1][15:0];
         res.blue = sum[2][15:0];
         res.last = (ox + 1 == (w / 2 < 1 ? 1 : w / 2)) && (oy + 1 == (h / 2 < 1 ? 1 : h / 2));
         hit = 1;
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
      return hit;
   endfunction

   always @(posedge clock) begin
      out_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         pixels_seen++;
         if (pending_pixels.size() == 0) begin
            $error("unexpected output pixel %h last %b", rsp_tdata, rsp_tlast);
            err_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[15:0] !== want.red) begin
               $error("red_out expected %h got %h", want.red, rsp_tdata[15:0]);
               err_count++;
            end
            if (rsp_tdata[31:16] !== want.green) begin
               $error("green_out expected %h got %h", want.green, rsp_tdata[31:16]);
               err_count++;
            end
            if (rsp_tdata[47:32] !== want.blue) begin
               $error("blue_out expected %h got %h", want.blue, rsp_tdata[47:32]);
               err_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("frame_last expected %b got %b", want.last, rsp_tlast);
               err_count++;
            end
         end
      end
   end

   task automatic send_pixel(logic [15:0] red, logic [15:0] green, logic [15:0] blue);
      out_pixel_type res;
      while (!steady && $urandom_range(99) < 26) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {blue, green, red};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
      if (downsample_pixel({blue, green, red}, res)) begin
         pending_pixels = {pending_pixels, res};
         if (karis_on) karis_pixels++;
      end
   endtask

   task automatic drain();
      int spin;
      req_tvalid <= 0;
      spin = 0;
      while (pending_pixels.size() != 0 && spin < 200000) begin
         @(posedge clock);
         spin++;
      end
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, val);
      csr_valid <= 0;
   endtask

   function automatic logic [15:0] pick_channel();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_frame(int unsigned w, int unsigned h, int unsigned stop_at);
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      for (int unsigned i = 0; i < stop_at; i++)
         send_pixel(pick_channel(), pick_channel(), pick_channel());
      frame_count++;
   endtask

   task automatic test_directed();
      logic [15:0] pat [4] = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};
      write_csr(CSR_IMAGE_WIDTH, '0);
      write_csr(CSR_IMAGE_HEIGHT, '0);
      send_pixel(16'hFFFF, 16'h0000, 16'h8001);
      write_csr(CSR_UNUSED, 13'h1FFF);
      for (int m = 0; m < 2; m++) begin
         write_csr(CSR_KARIS_MODE, CSR_DATA_W'(m));
         write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(4));
         write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(3));
         for (int i = 0; i < 12; i++)
            send_pixel(pat[i % 4], pat[(i + 1) % 4], pat[(i + 2) % 4]);
      end
   endtask

   task automatic test_size_limits();
      write_csr(CSR_KARIS_MODE, '0);
      send_frame(13'h1FFF, 1, 300);
      send_frame(1, 13'h1FFF, 300);
      write_csr(CSR_KARIS_MODE, CSR_DATA_W'(1));
      send_frame(2048, 1, 60);
   endtask

   task automatic test_random_frames();
      int unsigned w, h, n, goal;
      goal = pixels_sent + 500;
      while (pixels_sent < goal) begin
         steady = (pixels_sent + 300 > goal && pixels_sent + 150 < goal);
         write_csr(CSR_KARIS_MODE, CSR_DATA_W'($urandom_range(1)));
         w = ($urandom_range(7) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
         h = $urandom_range(9, 1);
         n = ($urandom_range(9) == 0) ? $urandom_range(w * h) : w * h;
         send_frame(w, h, n);
      end
      steady = 0;
   endtask

   initial begin
      width_reg = 1;
      height_reg = 1;
      karis_on = 0;
      col_pos = 0;
      row_pos = 0;
      foreach (evicted[k]) evicted[k] = '0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_size_limits();
      test_random_frames();
      drain();
      $display("covered %0d frames, %0d source pixels in, %0d output pixels out",
               frame_count, pixels_sent, pixels_seen);
      $display("karis-weighted outputs: %0d, size clamps and restarts included", karis_pixels);
      if (err_count == 0 && pending_pixels.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

### filelist.f
sv/b13ds_pkg.sv
sv/b13ds_window.sv
sv/b13ds_lane.sv
sv/b13ds_merge.sv
sv/bloom_13tap_downsample_unit.sv
bench/tb.sv
